>>> sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/frm_pkg.sv
// Types and constants for the four-level radix map.
`timescale 1ns / 1ps
`default_nettype none

package frm_pkg;

  localparam int POOL_BLOCKS_DEF = 64;
  localparam int BLOCK_ENTRIES   = 256;
  localparam int IDX_W           = 8;
  localparam int LEVELS          = 4;
  localparam int WORD_W          = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LINK,
    S_ALLOC,
    S_WRITE,
    S_DONE
  } walk_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              found;
    logic              status;
  } result_t;

endpackage

`default_nettype wire

>>> sv/four_level_radix_map.sv
// Top level of the four-level radix map: sequencer, node store, result register.
//
// Input channel (in_valid/in_ready): action, key, value. One request at a time;
// in_ready is high only while the sequencer is idle.
// Output channel (out_valid/out_ready): read_value, found, status, one result
// per request, in request order.
// Each request walks the levels with one memory read and one link check per
// level, then for insert/delete one pool check and one write per new level
// plus the leaf write. The node store's single read port and the chain of
// dependent link reads keep each walk serial.
// Results go into an output register; the next request is accepted while a
// result still waits there. A stalled receiver holds the sequencer in its
// done state only when a second result is ready before the first is taken.
// Reset: synchronous; the node store is then cleared one word per cycle,
// with in_ready low. The pool restarts at block 1.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module four_level_radix_map #(
  parameter int POOL_BLOCKS = frm_pkg::POOL_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_value,
  output logic             found,
  output logic             status
);

  localparam int BW    = $clog2(POOL_BLOCKS);
  localparam int AW    = BW + frm_pkg::IDX_W;
  localparam int DEPTH = POOL_BLOCKS * frm_pkg::BLOCK_ENTRIES;

  logic             done_valid;
  logic             done_ready;
  frm_pkg::result_t res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [31:0]      mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [31:0]      mem_rdata;

  frm_walker #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .BW(BW),
    .AW(AW)
  ) u_walker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .key(key),
    .value(value),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  frm_node_mem #(
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign done_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      read_value <= res.read_value;
      found      <= res.found;
      status     <= res.status;
    end
  end

  `ASSERT_IMPLIES(a_idle_not_done, clk, rst, done_valid, !in_ready, "accept while result pending")
  `ASSERT_NEXT(a_done_holds, clk, rst, done_valid && !done_ready, done_valid && $stable(res), "result dropped while stalled")
  `ASSERT_IMPLIES(a_status_clean, clk, rst, out_valid && status, !found && read_value == 32'd0, "failed write carries data")

endmodule

`default_nettype wire

>>> sv/frm_node_mem.sv
// Node store: synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module frm_node_mem #(
  parameter int DEPTH = frm_pkg::POOL_BLOCKS_DEF * frm_pkg::BLOCK_ENTRIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [frm_pkg::WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [frm_pkg::WORD_W-1:0] rdata
);

  logic [frm_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/frm_walker.sv
// Walk and allocation sequencer, including the post-reset clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module frm_walker #(
  parameter int POOL_BLOCKS = frm_pkg::POOL_BLOCKS_DEF,
  parameter int BW          = $clog2(POOL_BLOCKS),
  parameter int AW          = BW + frm_pkg::IDX_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 action,
  input  wire logic [31:0]                key,
  input  wire logic [31:0]                value,
  output logic                            done_valid,
  input  wire logic                       done_ready,
  output frm_pkg::result_t                res,
  output logic                            mem_we,
  output logic      [AW-1:0]              mem_waddr,
  output logic      [frm_pkg::WORD_W-1:0] mem_wdata,
  output logic      [AW-1:0]              mem_raddr,
  input  wire logic [frm_pkg::WORD_W-1:0] mem_rdata
);

  localparam int NW = $clog2(POOL_BLOCKS + 1);
  localparam int DEPTH = POOL_BLOCKS * frm_pkg::BLOCK_ENTRIES;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  frm_pkg::walk_state_t state, state_next;
  logic [1:0]    lvl, lvl_next;
  logic [BW-1:0] cur_blk, cur_blk_next;
  logic [NW-1:0] nfb, nfb_next;
  logic [AW-1:0] clr, clr_next;
  frm_pkg::result_t res_next;

  frm_pkg::action_t op;
  logic [31:0] op_key;
  logic [31:0] op_val;

  logic [frm_pkg::IDX_W-1:0] idx;
  logic       link_ok;
  logic [1:0] need;
  logic       short;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= frm_pkg::S_CLEAR;
      lvl     <= '0;
      cur_blk <= '0;
      nfb     <= NW'(1);
      clr     <= '0;
      res     <= '0;
    end else begin
      state   <= state_next;
      lvl     <= lvl_next;
      cur_blk <= cur_blk_next;
      nfb     <= nfb_next;
      clr     <= clr_next;
      res     <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op     <= frm_pkg::action_t'(action);
      op_key <= key;
      op_val <= (frm_pkg::action_t'(action) == frm_pkg::ACT_DELETE) ? 32'd0 : value;
    end
  end

  always_comb begin
    case (lvl)
      2'd0:    idx = op_key[31:24];
      2'd1:    idx = op_key[23:16];
      2'd2:    idx = op_key[15:8];
      default: idx = op_key[7:0];
    endcase
  end

  assign link_ok = (mem_rdata != '0) && (mem_rdata < 32'(POOL_BLOCKS));
  assign need    = 2'd3 - lvl;
  assign short   = ((NW+1)'(nfb) + (NW+1)'(need)) > (NW+1)'(POOL_BLOCKS);

  always_comb begin
    state_next   = state;
    lvl_next     = lvl;
    cur_blk_next = cur_blk;
    nfb_next     = nfb;
    clr_next     = clr;
    res_next     = res;
    in_ready     = 1'b0;
    done_valid   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = {cur_blk, idx};
    mem_wdata    = '0;
    mem_raddr    = {cur_blk, idx};
    case (state)
      frm_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        clr_next  = clr + AW'(1);
        if (clr == LAST_ADDR) begin
          state_next = frm_pkg::S_IDLE;
        end
      end
      frm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          lvl_next     = '0;
          cur_blk_next = '0;
          res_next     = '0;
          if (frm_pkg::action_t'(action) == frm_pkg::ACT_NONE) begin
            state_next = frm_pkg::S_DONE;
          end else begin
            state_next = frm_pkg::S_READ;
          end
        end
      end
      frm_pkg::S_READ: begin
        state_next = frm_pkg::S_LINK;
      end
      frm_pkg::S_LINK: begin
        if (lvl == 2'd3) begin
          res_next.read_value = mem_rdata;
          res_next.found      = 1'b1;
          state_next          = frm_pkg::S_DONE;
        end else if (link_ok) begin
          cur_blk_next = mem_rdata[BW-1:0];
          lvl_next     = lvl + 2'd1;
          if (lvl == 2'd2 && op != frm_pkg::ACT_GET) begin
            state_next = frm_pkg::S_ALLOC;
          end else begin
            state_next = frm_pkg::S_READ;
          end
        end else if (op == frm_pkg::ACT_GET) begin
          state_next = frm_pkg::S_DONE;
        end else begin
          state_next = frm_pkg::S_ALLOC;
        end
      end
      frm_pkg::S_ALLOC: begin
        if (short) begin
          res_next.status = 1'b1;
          state_next      = frm_pkg::S_DONE;
        end else begin
          state_next = frm_pkg::S_WRITE;
        end
      end
      frm_pkg::S_WRITE: begin
        mem_we = 1'b1;
        if (lvl == 2'd3) begin
          mem_wdata  = op_val;
          state_next = frm_pkg::S_DONE;
        end else begin
          mem_wdata    = 32'(nfb);
          cur_blk_next = nfb[BW-1:0];
          nfb_next     = nfb + NW'(1);
          lvl_next     = lvl + 2'd1;
        end
      end
      frm_pkg::S_DONE: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_next = frm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = frm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
